// File: rtl/exf_pkg.sv
// ----------------------------------------------------------------------------
// exf_pkg
// Shared constants and helper functions for the single-precision exp unit.
// ----------------------------------------------------------------------------
`default_nettype none

package exf_pkg;

    // pipeline depths
    localparam int FMA_LAT  = 6;
    localparam int RINT_LAT = 2;
    localparam int LATENCY  = 7 * FMA_LAT + RINT_LAT + 1;

    // binary32 codes
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

    // coefficients
    localparam logic [31:0] C_LOG2E  = 32'h3FB8_AA3B;
    localparam logic [31:0] C_LN2_HI = 32'hBF31_7200;
    localparam logic [31:0] C_LN2_LO = 32'hB5BF_BE8E;
    localparam logic [31:0] C_P0     = 32'h3D2B_CDE1;
    localparam logic [31:0] C_P1     = 32'h3E2C_09F1;
    localparam logic [31:0] C_P2     = 32'h3EFF_FFFE;
    localparam logic [31:0] C_P3     = 32'h3F7F_FD2D;
    localparam logic [31:0] C_P4     = 32'h3F7F_FFFA;

    function automatic logic is_nan(input logic [31:0] b);
        return b[30:0] > INF_MAG;
    endfunction

    function automatic logic is_inf(input logic [31:0] b);
        return b[30:0] == INF_MAG;
    endfunction

    function automatic logic is_zero(input logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    // position of the leading one, zero for a zero word
    function automatic logic [5:0] msb64(input logic [63:0] m);
        logic [5:0] p;
        p = 6'd0;
        for (int k = 0; k < 64; k++)
        begin
            if (m[k])
                p = 6'(k);
        end
        return p;
    endfunction

    // m >> sh, round to nearest even, sh in 1..64
    function automatic logic [63:0] rshift_round(input logic [63:0] m, input logic [6:0] sh);
        logic [63:0] q;
        logic [63:0] mask;
        logic [5:0]  gi;
        logic        guard;
        logic        sticky;
        q      = m >> sh;
        gi     = 6'(sh - 7'd1);
        guard  = m[gi];
        mask   = (64'd1 << gi) - 64'd1;
        sticky = |(m & mask);
        if (guard && (sticky || q[0]))
            q = q + 64'd1;
        return q;
    endfunction

    // right shift with sticky jam into the low bit
    function automatic logic [63:0] jam64(input logic [63:0] m, input logic [11:0] d);
        logic [63:0] mask;
        logic [5:0]  sh;
        sh   = d[5:0];
        mask = (64'd1 << sh) - 64'd1;
        if (d >= 12'd63)
            return {63'd0, |m};
        return (m >> sh) | {63'd0, |(m & mask)};
    endfunction

endpackage

`default_nettype wire

// File: rtl/exp_float32_approx_unit.sv
// ----------------------------------------------------------------------------
// exp_float32_approx_unit
// Pipelined binary32 e^x: range reduction by ln2 and a degree-4 polynomial.
// ----------------------------------------------------------------------------
// usage
//   a transaction is taken at a rising edge where start is high and busy is
//   low; busy stays low, so a new x_bits may be sent in every cycle
//   the result appears on exp_bits for one cycle with done high, in the
//   order the inputs were taken
//   throughput is one result per cycle; the path is seven six-stage fused
//   multiply-add units, a two-stage rounding unit and an output register
//   the receiver cannot hold results off, so nothing inside ever stalls
//   reset clears every valid bit in the pipeline; transactions in flight are
//   dropped and done stays low until new ones come through
//   overflow and underflow wrap through the exponent field, no saturation
// ----------------------------------------------------------------------------
`default_nettype none

module exp_float32_approx_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] x_bits,
    output logic             done,
    output logic      [31:0] exp_bits
);

    logic        t_valid, r_valid, f1_valid, f_valid;
    logic        p1_valid, p2_valid, p3_valid, p4_valid;
    logic [31:0] t, r, f1, f, p1, p2, p3, p4;
    logic [31:0] x_d, r_d, f_d1, f_d2, f_d3;
    logic [8:0]  i_low, i_d;

    assign busy = 1'b0;

    // t = x * log2(e)
    exf_fma u_fma_t (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .a(x_bits), .b(exf_pkg::C_LOG2E), .c(exf_pkg::SIGN_BIT),
        .out_valid(t_valid), .y(t)
    );

    exf_rint u_rint (
        .clk(clk), .rst_n(rst_n), .in_valid(t_valid), .t(t),
        .out_valid(r_valid), .r(r), .i_low(i_low)
    );

    exf_delay #(.WIDTH(32), .DEPTH(exf_pkg::FMA_LAT + exf_pkg::RINT_LAT)) u_dly_x (
        .clk(clk), .d(x_bits), .q(x_d)
    );

    // two-step reduction by ln2
    exf_fma u_fma_f1 (
        .clk(clk), .rst_n(rst_n), .in_valid(r_valid),
        .a(r), .b(exf_pkg::C_LN2_HI), .c(x_d),
        .out_valid(f1_valid), .y(f1)
    );

    exf_delay #(.WIDTH(32), .DEPTH(exf_pkg::FMA_LAT)) u_dly_r (
        .clk(clk), .d(r), .q(r_d)
    );

    exf_fma u_fma_f2 (
        .clk(clk), .rst_n(rst_n), .in_valid(f1_valid),
        .a(r_d), .b(exf_pkg::C_LN2_LO), .c(f1),
        .out_valid(f_valid), .y(f)
    );

    // horner polynomial
    exf_fma u_fma_p1 (
        .clk(clk), .rst_n(rst_n), .in_valid(f_valid),
        .a(exf_pkg::C_P0), .b(f), .c(exf_pkg::C_P1),
        .out_valid(p1_valid), .y(p1)
    );

    exf_delay #(.WIDTH(32), .DEPTH(exf_pkg::FMA_LAT)) u_dly_f1 (
        .clk(clk), .d(f), .q(f_d1)
    );

    exf_fma u_fma_p2 (
        .clk(clk), .rst_n(rst_n), .in_valid(p1_valid),
        .a(p1), .b(f_d1), .c(exf_pkg::C_P2),
        .out_valid(p2_valid), .y(p2)
    );

    exf_delay #(.WIDTH(32), .DEPTH(exf_pkg::FMA_LAT)) u_dly_f2 (
        .clk(clk), .d(f_d1), .q(f_d2)
    );

    exf_fma u_fma_p3 (
        .clk(clk), .rst_n(rst_n), .in_valid(p2_valid),
        .a(p2), .b(f_d2), .c(exf_pkg::C_P3),
        .out_valid(p3_valid), .y(p3)
    );

    exf_delay #(.WIDTH(32), .DEPTH(exf_pkg::FMA_LAT)) u_dly_f3 (
        .clk(clk), .d(f_d2), .q(f_d3)
    );

    exf_fma u_fma_p4 (
        .clk(clk), .rst_n(rst_n), .in_valid(p3_valid),
        .a(p3), .b(f_d3), .c(exf_pkg::C_P4),
        .out_valid(p4_valid), .y(p4)
    );

    // only the low nine bits of the integer reach the exponent field
    exf_delay #(.WIDTH(9), .DEPTH(6 * exf_pkg::FMA_LAT)) u_dly_i (
        .clk(clk), .d(i_low), .q(i_d)
    );

    logic        done_reg;
    logic [31:0] exp_reg;

    always_ff @(posedge clk)
    begin
        exp_reg <= {i_d, 23'd0} + p4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= p4_valid;
    end

    assign done     = done_reg;
    assign exp_bits = exp_reg;

endmodule

`default_nettype wire

// File: rtl/exf_delay.sv
// ----------------------------------------------------------------------------
// exf_delay
// Fixed-depth register line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module exf_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6
) (
    input  wire logic             clk,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int k = 1; k < DEPTH; k++)
        begin
            tap_reg[k] <= tap_reg[k-1];
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/exf_fma.sv
// ----------------------------------------------------------------------------
// exf_fma
// Six-stage binary32 fused multiply-add, round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module exf_fma (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [31:0] c,
    output logic             out_valid,
    output logic      [31:0] y
);

    // ---------------- stage 1: special cases, unpack, multiply
    logic               sp1, sc1, spec1;
    logic [31:0]        sval1;
    logic [23:0]        ma1, mb1, mc1;
    logic signed [11:0] ea1, eb1, ec1;

    always_comb
    begin
        sp1   = a[31] ^ b[31];
        sc1   = c[31];
        spec1 = 1'b1;
        sval1 = 32'd0;
        if (exf_pkg::is_nan(a))
            sval1 = a | exf_pkg::QUIET_BIT;
        else if (exf_pkg::is_nan(b))
            sval1 = b | exf_pkg::QUIET_BIT;
        else if (exf_pkg::is_nan(c))
            sval1 = c | exf_pkg::QUIET_BIT;
        else if (exf_pkg::is_inf(a) || exf_pkg::is_inf(b))
        begin
            if (exf_pkg::is_zero(a) || exf_pkg::is_zero(b))
                sval1 = exf_pkg::DEFAULT_NAN;
            else if (exf_pkg::is_inf(c) && (sc1 != sp1))
                sval1 = exf_pkg::DEFAULT_NAN;
            else
                sval1 = {sp1, exf_pkg::INF_MAG};
        end
        else if (exf_pkg::is_inf(c))
            sval1 = c;
        else if (exf_pkg::is_zero(a) || exf_pkg::is_zero(b))
        begin
            if (!exf_pkg::is_zero(c))
                sval1 = c;
            else
                sval1 = (sp1 == sc1) ? {sp1, 31'd0} : 32'd0;
        end
        else
            spec1 = 1'b0;

        ma1 = {(a[30:23] != 8'd0), a[22:0]};
        mb1 = {(b[30:23] != 8'd0), b[22:0]};
        mc1 = {(c[30:23] != 8'd0), c[22:0]};
        ea1 = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
        eb1 = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
        ec1 = (c[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, c[30:23]}) - 12'sd150;
    end

    logic               s1_valid_reg;
    logic               s1_spec_reg, s1_sp_reg, s1_sc_reg, s1_zc_reg;
    logic [31:0]        s1_sval_reg;
    logic [47:0]        s1_prod_reg;
    logic signed [11:0] s1_ep_reg, s1_ec_reg;
    logic [23:0]        s1_mc_reg;

    always_ff @(posedge clk)
    begin
        s1_spec_reg <= spec1;
        s1_sval_reg <= sval1;
        s1_sp_reg   <= sp1;
        s1_sc_reg   <= sc1;
        s1_zc_reg   <= exf_pkg::is_zero(c);
        s1_prod_reg <= ma1 * mb1;
        s1_ep_reg   <= ea1 + eb1;
        s1_mc_reg   <= mc1;
        s1_ec_reg   <= ec1;
    end

    // ---------------- stage 2: normalize both operands to bit 61
    logic [5:0]         shp2, shc2;
    logic [63:0]        mp2, mc2;
    logic signed [11:0] ep2, ec2;

    always_comb
    begin
        shp2 = 6'd61 - exf_pkg::msb64({16'd0, s1_prod_reg});
        shc2 = 6'd61 - exf_pkg::msb64({40'd0, s1_mc_reg});
        mp2  = {16'd0, s1_prod_reg} << shp2;
        mc2  = {40'd0, s1_mc_reg} << shc2;
        ep2  = s1_ep_reg - $signed({6'd0, shp2});
        ec2  = s1_ec_reg - $signed({6'd0, shc2});
    end

    logic               s2_valid_reg;
    logic               s2_spec_reg, s2_sp_reg, s2_sc_reg, s2_zc_reg;
    logic [31:0]        s2_sval_reg;
    logic [63:0]        s2_mp_reg, s2_mc_reg;
    logic signed [11:0] s2_ep_reg, s2_ec_reg;

    always_ff @(posedge clk)
    begin
        s2_spec_reg <= s1_spec_reg;
        s2_sval_reg <= s1_sval_reg;
        s2_sp_reg   <= s1_sp_reg;
        s2_sc_reg   <= s1_sc_reg;
        s2_zc_reg   <= s1_zc_reg;
        s2_mp_reg   <= mp2;
        s2_mc_reg   <= mc2;
        s2_ep_reg   <= ep2;
        s2_ec_reg   <= ec2;
    end

    // ---------------- stage 3: align exponents
    logic signed [11:0] diff3, e3;
    logic [63:0]        mp3, mc3;

    always_comb
    begin
        diff3 = s2_ep_reg - s2_ec_reg;
        mp3   = s2_mp_reg;
        mc3   = s2_mc_reg;
        e3    = s2_ep_reg;
        if (s2_zc_reg)
            mc3 = 64'd0;
        else if (!diff3[11])
            mc3 = exf_pkg::jam64(s2_mc_reg, diff3);
        else
        begin
            mp3 = exf_pkg::jam64(s2_mp_reg, 12'(-diff3));
            e3  = s2_ec_reg;
        end
    end

    logic               s3_valid_reg;
    logic               s3_spec_reg, s3_sp_reg, s3_sc_reg, s3_zc_reg;
    logic [31:0]        s3_sval_reg;
    logic [63:0]        s3_mp_reg, s3_mc_reg;
    logic signed [11:0] s3_e_reg;

    always_ff @(posedge clk)
    begin
        s3_spec_reg <= s2_spec_reg;
        s3_sval_reg <= s2_sval_reg;
        s3_sp_reg   <= s2_sp_reg;
        s3_sc_reg   <= s2_sc_reg;
        s3_zc_reg   <= s2_zc_reg;
        s3_mp_reg   <= mp3;
        s3_mc_reg   <= mc3;
        s3_e_reg    <= e3;
    end

    // ---------------- stage 4: add or subtract magnitudes
    logic        spec4, sign4;
    logic [31:0] sval4;
    logic [63:0] m4;

    always_comb
    begin
        spec4 = s3_spec_reg;
        sval4 = s3_sval_reg;
        sign4 = s3_sp_reg;
        m4    = s3_mp_reg + s3_mc_reg;
        if (!s3_zc_reg && (s3_sp_reg != s3_sc_reg))
        begin
            if (s3_mp_reg == s3_mc_reg)
            begin
                // exact cancellation gives +0
                if (!s3_spec_reg)
                begin
                    spec4 = 1'b1;
                    sval4 = 32'd0;
                end
            end
            else if (s3_mp_reg > s3_mc_reg)
                m4 = s3_mp_reg - s3_mc_reg;
            else
            begin
                m4    = s3_mc_reg - s3_mp_reg;
                sign4 = s3_sc_reg;
            end
        end
    end

    logic               s4_valid_reg;
    logic               s4_spec_reg, s4_sign_reg;
    logic [31:0]        s4_sval_reg;
    logic [63:0]        s4_m_reg;
    logic signed [11:0] s4_e_reg;

    always_ff @(posedge clk)
    begin
        s4_spec_reg <= spec4;
        s4_sval_reg <= sval4;
        s4_sign_reg <= sign4;
        s4_m_reg    <= m4;
        s4_e_reg    <= s3_e_reg;
    end

    // ---------------- stage 5: leading one and rounding shift
    logic signed [11:0] sha5, shb5;

    always_comb
    begin
        sha5 = $signed({6'd0, exf_pkg::msb64(s4_m_reg)}) - 12'sd23;
        shb5 = -12'sd149 - s4_e_reg;
    end

    logic               s5_valid_reg;
    logic               s5_spec_reg, s5_sign_reg;
    logic [31:0]        s5_sval_reg;
    logic [63:0]        s5_m_reg;
    logic signed [11:0] s5_e_reg, s5_sh_reg;

    always_ff @(posedge clk)
    begin
        s5_spec_reg <= s4_spec_reg;
        s5_sval_reg <= s4_sval_reg;
        s5_sign_reg <= s4_sign_reg;
        s5_m_reg    <= s4_m_reg;
        s5_e_reg    <= s4_e_reg;
        s5_sh_reg   <= (shb5 > sha5) ? shb5 : sha5;
    end

    // ---------------- stage 6: shift, round, pack
    logic [63:0]        qw6;
    logic [24:0]        q6;
    logic signed [11:0] lsb6, biased6, nsh6;
    logic [31:0]        y6;

    always_comb
    begin
        nsh6 = -s5_sh_reg;
        if (s5_sh_reg[11] || (s5_sh_reg == 12'sd0))
            qw6 = s5_m_reg << nsh6[5:0];
        else if (s5_sh_reg > 12'sd64)
            qw6 = 64'd0;
        else
            qw6 = exf_pkg::rshift_round(s5_m_reg, s5_sh_reg[6:0]);
        q6   = qw6[24:0];
        lsb6 = s5_e_reg + s5_sh_reg;
        if (q6[24])
        begin
            q6   = q6 >> 1;
            lsb6 = lsb6 + 12'sd1;
        end
        biased6 = lsb6 + 12'sd150;
        if (q6[23])
        begin
            if (biased6 >= 12'sd255)
                y6 = {s5_sign_reg, exf_pkg::INF_MAG};
            else
                y6 = {s5_sign_reg, biased6[7:0], q6[22:0]};
        end
        else
            y6 = {s5_sign_reg, 8'd0, q6[22:0]};
        if (s5_spec_reg)
            y6 = s5_sval_reg;
    end

    logic        s6_valid_reg;
    logic [31:0] y_reg;

    always_ff @(posedge clk)
    begin
        y_reg <= y6;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    assign out_valid = s6_valid_reg;
    assign y         = y_reg;

endmodule

`default_nettype wire

// File: rtl/exf_rint.sv
// ----------------------------------------------------------------------------
// exf_rint
// Two-stage round to integral value, plus the low bits of the int32 form.
// ----------------------------------------------------------------------------
`default_nettype none

module exf_rint (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [31:0] t,
    output logic             out_valid,
    output logic      [31:0] r,
    output logic      [8:0]  i_low
);

    // ---------------- stage 1: round the fraction away
    logic        pass1;
    logic [31:0] pval1;
    logic [23:0] m1;
    logic [7:0]  ne1;
    logic [63:0] rw1;
    logic [24:0] mr1;

    always_comb
    begin
        pass1 = exf_pkg::is_nan(t) || (t[30:23] >= 8'd150) || exf_pkg::is_zero(t);
        pval1 = exf_pkg::is_nan(t) ? (t | exf_pkg::QUIET_BIT) : t;
        m1    = {(t[30:23] != 8'd0), t[22:0]};
        ne1   = (t[30:23] == 8'd0) ? 8'd149 : 8'd150 - t[30:23];
        rw1   = exf_pkg::rshift_round({40'd0, m1}, 7'(ne1));
        mr1   = (ne1 >= 8'd25) ? 25'd0 : rw1[24:0];
    end

    logic        s1_valid_reg;
    logic        s1_pass_reg, s1_sign_reg;
    logic [31:0] s1_pval_reg;
    logic [24:0] s1_m_reg;

    always_ff @(posedge clk)
    begin
        s1_pass_reg <= pass1;
        s1_pval_reg <= pval1;
        s1_sign_reg <= t[31];
        s1_m_reg    <= mr1;
    end

    // ---------------- stage 2: repack and integer conversion
    logic [5:0]  p2;
    logic [63:0] sw2;
    logic [22:0] frac2;
    logic [31:0] r2;
    logic [8:0]  i2;
    logic [7:0]  ex2, e2;
    logic [32:0] mag2;

    always_comb
    begin
        p2    = exf_pkg::msb64({39'd0, s1_m_reg});
        sw2   = {39'd0, s1_m_reg} << (6'd23 - p2);
        frac2 = (p2 == 6'd24) ? s1_m_reg[23:1] : sw2[22:0];
        ex2   = s1_pval_reg[30:23];
        e2    = ex2 - 8'd150;
        mag2  = {9'd0, (ex2 != 8'd0), s1_pval_reg[22:0]} << e2[3:0];
        if (s1_pass_reg)
        begin
            r2 = s1_pval_reg;
            if ((ex2 == 8'hFF) || exf_pkg::is_zero(s1_pval_reg) || (e2 > 8'd8))
                i2 = 9'd0;
            else if (s1_pval_reg[31])
                i2 = (mag2 > 33'h0_8000_0000) ? 9'd0 : 9'(-mag2);
            else
                i2 = (mag2 > 33'h0_7FFF_FFFF) ? 9'd0 : mag2[8:0];
        end
        else
        begin
            if (s1_m_reg == 25'd0)
                r2 = {s1_sign_reg, 31'd0};
            else
                r2 = {s1_sign_reg, 8'(p2) + 8'd127, frac2};
            i2 = s1_sign_reg ? 9'(-s1_m_reg[8:0]) : s1_m_reg[8:0];
        end
    end

    logic        s2_valid_reg;
    logic [31:0] r_reg;
    logic [8:0]  i_reg;

    always_ff @(posedge clk)
    begin
        r_reg <= r2;
        i_reg <= i2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign r         = r_reg;
    assign i_low     = i_reg;

endmodule

`default_nettype wire

// File: rtl/exf_checker.sv
// ----------------------------------------------------------------------------
// exf_checker
// Port-level checks on latency and special-value results of the exp unit.
// ----------------------------------------------------------------------------
`default_nettype none

module exf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [31:0] x_bits,
    input wire logic        done,
    input wire logic [31:0] exp_bits
);

    localparam int LAT = exf_pkg::LATENCY;

    // the unit never refuses a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a transaction at fixed latency");

    // a nan argument comes back quieted
    a_nan: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(x_bits[30:0], LAT) > 31'h7F80_0000)
        |-> exp_bits == ($past(x_bits, LAT) | exf_pkg::QUIET_BIT))
        else $error("nan not propagated");

    // infinite argument gives the default nan
    a_inf: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(x_bits[30:0], LAT) == 31'h7F80_0000)
        |-> exp_bits == exf_pkg::DEFAULT_NAN)
        else $error("infinity not mapped to default nan");

    // zero argument gives the last polynomial coefficient
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(x_bits[30:0], LAT) == 31'd0)
        |-> exp_bits == exf_pkg::C_P4)
        else $error("wrong result for zero");

endmodule

bind exp_float32_approx_unit exf_checker u_exf_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .x_bits(x_bits), .done(done), .exp_bits(exp_bits)
);

`default_nettype wire
